/* rtl/sma_pkg.sv */
package sma_pkg;

  localparam int SAMPLE_W = 16;
  localparam int WIN_W    = 5;
  localparam int DATA_W   = 32;
  localparam int PDATA_W  = 32;
  localparam int PADDR_W  = 3;

  localparam logic [0:0]       REG_WINDOW = 1'b0;
  localparam logic [WIN_W-1:0] WIN_RESET  = 5'd1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic load;
    logic rot;
    logic acc;
    logic prep;
    logic step;
    logic finish;
  } cmd_t;

endpackage

/* rtl/sma_ctrl.sv */
module sma_ctrl #(
  parameter int MAX_WINDOW = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]       win_n_i,
  output sma_pkg::cmd_t                         cmd_o
);

  localparam int DEPTH   = MAX_WINDOW - 1;
  localparam int SUM_W   = sma_pkg::SAMPLE_W + $clog2(MAX_WINDOW);
  localparam int CNT_MAX = (SUM_W > DEPTH) ? SUM_W : DEPTH;
  localparam int CNT_W   = $clog2(CNT_MAX);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ACC  = 3'd1;
  localparam logic [2:0] S_PREP = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = S_ACC;
        end
      end
      S_ACC: begin
        cmd_o.rot = 1'b1;
        cmd_o.acc = (int'(cnt_q) + 1) < int'(win_n_i);
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DEPTH - 1)) begin
          cnt_d   = '0;
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        cnt_d      = '0;
        state_d    = S_DIV;
      end
      S_DIV: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(SUM_W - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_acc_in_rot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.acc |-> cmd_o.rot)
    else $error("accumulate outside rotation");

  a_load_to_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == S_ACC))
    else $error("load did not start accumulation");

  a_finish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> (out_valid_q && state_q == S_IDLE))
    else $error("finish did not present result");

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && cnt_q == CNT_W'(SUM_W - 1)) |=> (state_q == S_DONE))
    else $error("divide length wrong");

endmodule

/* rtl/sma_dp.sv */
module sma_dp #(
  parameter int MAX_WINDOW = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  sma_pkg::cmd_t                   cmd_i,
  input  logic [$clog2(MAX_WINDOW+1)-1:0] win_n_i,
  input  sma_pkg::sample_t                samp_i [2],
  output sma_pkg::sample_t                avg_o  [2]
);

  localparam int DEPTH = MAX_WINDOW - 1;
  localparam int SW    = sma_pkg::SAMPLE_W;
  localparam int SUM_W = SW + $clog2(MAX_WINDOW);
  localparam int NW    = $clog2(MAX_WINDOW+1);
  localparam int EXT_W = SUM_W - SW;

  sma_pkg::sample_t   hist_q [2][DEPTH];
  sma_pkg::sample_t   cur_q  [2];
  sma_pkg::sample_t   out_q  [2];
  logic [SUM_W-1:0]   sum_q  [2];
  logic [SUM_W-1:0]   quo_q  [2];
  logic [NW-1:0]      rem_q  [2];
  logic               neg_q  [2];

  logic [NW:0]        rem_sh [2];
  logic               ge     [2];
  logic [SUM_W-1:0]   mag    [2];
  logic [SUM_W-1:0]   res    [2];
  logic [NW:0]        rem_sub[2];

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      rem_sh[c]  = {rem_q[c], quo_q[c][SUM_W-1]};
      ge[c]      = rem_sh[c] >= {1'b0, win_n_i};
      rem_sub[c] = rem_sh[c] - {1'b0, win_n_i};
      mag[c]     = sum_q[c][SUM_W-1] ? (~sum_q[c] + 1'b1) : sum_q[c];
      res[c]     = neg_q[c] ? (~quo_q[c] + 1'b1) : quo_q[c];
      avg_o[c]   = out_q[c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 2; c++) begin
        for (int i = 0; i < DEPTH; i++) begin
          hist_q[c][i] <= '0;
        end
      end
    end else begin
      for (int c = 0; c < 2; c++) begin
        if (cmd_i.rot) begin
          for (int i = 0; i < DEPTH - 1; i++) begin
            hist_q[c][i] <= hist_q[c][i+1];
          end
          hist_q[c][DEPTH-1] <= hist_q[c][0];
        end else if (cmd_i.finish) begin
          for (int i = DEPTH - 1; i > 0; i--) begin
            hist_q[c][i] <= hist_q[c][i-1];
          end
          hist_q[c][0] <= cur_q[c];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 2; c++) begin
      if (cmd_i.load) begin
        cur_q[c] <= samp_i[c];
        sum_q[c] <= {{EXT_W{samp_i[c][SW-1]}}, samp_i[c]};
      end
      if (cmd_i.acc) begin
        sum_q[c] <= sum_q[c] + {{EXT_W{hist_q[c][0][SW-1]}}, hist_q[c][0]};
      end
      if (cmd_i.prep) begin
        neg_q[c] <= sum_q[c][SUM_W-1];
        quo_q[c] <= mag[c];
        rem_q[c] <= '0;
      end
      if (cmd_i.step) begin
        rem_q[c] <= ge[c] ? rem_sub[c][NW-1:0] : rem_sh[c][NW-1:0];
        quo_q[c] <= {quo_q[c][SUM_W-2:0], ge[c]};
      end
      if (cmd_i.finish) begin
        out_q[c] <= res[c][SW-1:0];
      end
    end
  end

endmodule

/* rtl/stereo_moving_average.sv */
// Channel   Dir  Handshake                     Fields (low bit first)
// s_axis    in   s_axis_tvalid/s_axis_tready   left_sample[15:0], right_sample[31:16]
// m_axis    out  m_axis_tvalid/m_axis_tready   left_average[15:0], right_average[31:16]
// apb       in   psel/penable/pwrite/pready    window_length at byte address 0
//
// Each item goes through a full rotation of the history line for the sum, then a
// one-bit-per-cycle divider.
// Reset clears the history to zero and sets the window to 1.
// A finished result waits in the output register; the next item is taken meanwhile,
// and only the final write-back stalls while the output is still held.
module stereo_moving_average #(
  parameter int MAX_WINDOW = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [sma_pkg::DATA_W-1:0]          s_axis_tdata,  // left_sample, right_sample
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [sma_pkg::DATA_W-1:0]          m_axis_tdata,  // left_average, right_average
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sma_pkg::PADDR_W-1:0]         paddr,
  input  logic [sma_pkg::PDATA_W-1:0]         pwdata,
  output logic [sma_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready
);

  localparam int NW = $clog2(MAX_WINDOW+1);
  localparam int SW = sma_pkg::SAMPLE_W;

  logic [sma_pkg::WIN_W-1:0] win_q;
  logic [NW-1:0]             win_n;
  sma_pkg::cmd_t             cmd;
  sma_pkg::sample_t          samp [2];
  sma_pkg::sample_t          avg  [2];
  logic                      reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == sma_pkg::REG_WINDOW);
  assign prdata  = reg_sel ? {{(sma_pkg::PDATA_W-sma_pkg::WIN_W){1'b0}}, win_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= sma_pkg::WIN_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      win_q <= pwdata[sma_pkg::WIN_W-1:0];
    end
  end

  always_comb begin
    if (win_q == '0) begin
      win_n = NW'(1);
    end else if (int'(win_q) > MAX_WINDOW) begin
      win_n = NW'(MAX_WINDOW);
    end else begin
      win_n = NW'(win_q);
    end
  end

  assign samp[0]      = s_axis_tdata[SW-1:0];
  assign samp[1]      = s_axis_tdata[2*SW-1:SW];
  assign m_axis_tdata = {avg[1], avg[0]};

  sma_ctrl #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .win_n_i     (win_n),
    .cmd_o       (cmd)
  );

  sma_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .win_n_i (win_n),
    .samp_i  (samp),
    .avg_o   (avg)
  );

endmodule

/* tb/stereo_moving_average_tb.sv */
`timescale 1ns / 1ps
module stereo_moving_average_tb;

  localparam int MAX_WINDOW = 16;
  localparam int HIST_DEPTH = MAX_WINDOW - 1;
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_PCT = 33;
  localparam int PHASES = 10;
  localparam logic [sma_pkg::PADDR_W-1:0] WINDOW_ADDR = {sma_pkg::REG_WINDOW, 2'b00};
  localparam logic [sma_pkg::PADDR_W-1:0] UNUSED_ADDR = {~sma_pkg::REG_WINDOW, 2'b00};
  localparam sma_pkg::sample_t S_MAX = 16'sh7FFF;
  localparam sma_pkg::sample_t S_MIN = 16'sh8000;

  class average_tracker;
    logic [sma_pkg::WIN_W-1:0] window_length;
    sma_pkg::sample_t left_hist[HIST_DEPTH];
    sma_pkg::sample_t right_hist[HIST_DEPTH];
    logic [sma_pkg::DATA_W-1:0] pending[$];
    int failures;

    function new();
      window_length = sma_pkg::WIN_RESET;
      foreach (left_hist[k]) begin
        left_hist[k] = '0;
        right_hist[k] = '0;
      end
      failures = 0;
    endfunction

    function void write_register(logic [sma_pkg::PADDR_W-1:0] addr,
                                 logic [sma_pkg::PDATA_W-1:0] data);
      if (addr[sma_pkg::PADDR_W-1:2] == sma_pkg::REG_WINDOW) begin
        window_length = data[sma_pkg::WIN_W-1:0];
      end
    endfunction

    // mean over the current pair and the newest n-1 stored pairs, then shift
    function void take_pair(sma_pkg::sample_t left, sma_pkg::sample_t right);
      int n;
      int lsum;
      int rsum;
      n = window_length;
      if (n < 1) n = 1;
      if (n > MAX_WINDOW) n = MAX_WINDOW;
      lsum = left;
      rsum = right;
      for (int k = 0; k < n - 1; k++) begin
        lsum += left_hist[k];
        rsum += right_hist[k];
      end
      for (int k = HIST_DEPTH - 1; k > 0; k--) begin
        left_hist[k] = left_hist[k-1];
        right_hist[k] = right_hist[k-1];
      end
      left_hist[0] = left;
      right_hist[0] = right;
      pending.push_back({sma_pkg::sample_t'(rsum / n), sma_pkg::sample_t'(lsum / n)});
    endfunction

    function void compare(string field, int expected_val, int actual_val);
      if (expected_val != actual_val) begin
        $error("%s mismatch: expected %0d, actual %0d", field, expected_val, actual_val);
        failures++;
      end
    endfunction

    function void check_average(logic [sma_pkg::DATA_W-1:0] data);
      logic [sma_pkg::DATA_W-1:0] want;
      if (pending.size() == 0) begin
        $error("unexpected average item %h", data);
        failures++;
        return;
      end
      want = pending.pop_front();
      compare("left_average", sma_pkg::sample_t'(want[15:0]),
              sma_pkg::sample_t'(data[15:0]));
      compare("right_average", sma_pkg::sample_t'(want[31:16]),
              sma_pkg::sample_t'(data[31:16]));
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [sma_pkg::DATA_W-1:0]    s_axis_tdata;   // left_sample, right_sample
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [sma_pkg::DATA_W-1:0]    m_axis_tdata;   // left_average, right_average
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [sma_pkg::PADDR_W-1:0]   paddr;
  logic [sma_pkg::PDATA_W-1:0]   pwdata;
  logic [sma_pkg::PDATA_W-1:0]   prdata;
  logic                          pready;

  average_tracker tracker = new();
  int idle_pct = IDLE_PCT;
  bit hold_req = 1'b0;

  stereo_moving_average #(.MAX_WINDOW(MAX_WINDOW)) DUT (.*);

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic sma_pkg::sample_t rand_sample();
    case ($urandom_range(0, 9))
      0: return S_MAX;
      1: return S_MIN;
      2: return sma_pkg::sample_t'(int'($urandom_range(0, 16)) - 8);
      default: return sma_pkg::sample_t'($urandom());
    endcase
  endfunction

  task automatic send_pair(input sma_pkg::sample_t left, input sma_pkg::sample_t right);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {right, left};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tracker.take_pair(left, right);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending.size() != 0) @(negedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [sma_pkg::PADDR_W-1:0] addr,
                            input logic [sma_pkg::PDATA_W-1:0] data,
                            output logic [sma_pkg::PDATA_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_register(input logic [sma_pkg::PADDR_W-1:0] addr,
                              input logic [sma_pkg::PDATA_W-1:0] data);
    logic [sma_pkg::PDATA_W-1:0] rd;
    apb_access(1'b1, addr, data, rd);
    tracker.write_register(addr, data);
    apb_access(1'b0, WINDOW_ADDR, '0, rd);
    tracker.compare("window_length", tracker.window_length, rd);
  endtask

  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tracker.check_average(m_axis_tdata);
    end
  end

  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [sma_pkg::PDATA_W-1:0] wdata;
    sma_pkg::sample_t left;
    int count;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    rst_ni <= 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset window of one: pass-through
    send_pair(S_MAX, S_MIN);
    send_pair(S_MIN, S_MAX);
    send_pair(sma_pkg::sample_t'(0), sma_pkg::sample_t'(-1));
    drain();
    // longer window picks up older samples and the reset zeros at once
    set_register(WINDOW_ADDR, 32'd16);
    send_pair(S_MIN, S_MAX);
    send_pair(S_MAX, S_MIN);
    send_pair(sma_pkg::sample_t'(-1), sma_pkg::sample_t'(1));
    send_pair(S_MIN, S_MIN);
    send_pair(S_MAX, S_MAX);
    send_pair(sma_pkg::sample_t'(1), sma_pkg::sample_t'(-1));
    drain();
    // zero window after dropping the upper bits
    set_register(WINDOW_ADDR, 32'h20);
    send_pair(S_MAX, S_MIN);
    send_pair(sma_pkg::sample_t'(-3), sma_pkg::sample_t'(3));
    send_pair(S_MIN, S_MAX);
    drain();
    // oversized window saturates
    set_register(WINDOW_ADDR, 32'hFFFF_FFFF);
    send_pair(S_MIN, S_MIN);
    send_pair(S_MAX, S_MIN);
    send_pair(sma_pkg::sample_t'(-7), sma_pkg::sample_t'(5));
    drain();
    // write to an unmapped index is dropped
    set_register(UNUSED_ADDR, 32'h2);
    send_pair(sma_pkg::sample_t'(100), sma_pkg::sample_t'(-100));
    send_pair(S_MIN, S_MAX);

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      wdata = $urandom();
      case (phase)
        0: wdata[sma_pkg::WIN_W-1:0] = 5'd16;
        1: wdata[sma_pkg::WIN_W-1:0] = 5'd1;
        2: wdata[sma_pkg::WIN_W-1:0] = 5'd0;
        3: wdata[sma_pkg::WIN_W-1:0] = 5'd31;
        default: wdata[sma_pkg::WIN_W-1:0] = sma_pkg::WIN_W'($urandom_range(0, 31));
      endcase
      set_register(WINDOW_ADDR, wdata);
      if ($urandom_range(0, 3) == 0) set_register(UNUSED_ADDR, $urandom());
      idle_pct = (phase == 4) ? 0 : IDLE_PCT;
      if (phase == 6) hold_req = 1'b1;
      count = $urandom_range(95, 115);
      for (int i = 0; i < count; i++) begin
        if (phase == 0 && i < 32) begin
          left = (i < 16) ? S_MAX : S_MIN;
          send_pair(left, ~left);
        end else begin
          send_pair(rand_sample(), rand_sample());
        end
      end
    end
    drain();
    repeat (60) @(negedge clk_i);

    if (tracker.failures == 0 && tracker.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/sma_pkg.sv
rtl/sma_ctrl.sv
rtl/sma_dp.sv
rtl/stereo_moving_average.sv
tb/stereo_moving_average_tb.sv
